// ===== src/positional_list_engine_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define PLE_ASSERT_IMPL(label, ante, cons, msg) \
  `PLE_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== src/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg
// Types and codes shared by the positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

  // Command codes carried on the input word.
  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT_AT = 3'd1,
    CMD_REM_LAST  = 3'd2,
    CMD_REM_AT    = 3'd3,
    CMD_FIND_KEY  = 3'd4,
    CMD_CHECK_POS = 3'd5,
    CMD_CLEAR     = 3'd6
  } ple_cmd_e;

  // Status codes carried on the result word.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } ple_status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    PLE_IDLE,
    PLE_SHIFT_UP,
    PLE_PUT,
    PLE_SHIFT_DN,
    PLE_SCAN
  } ple_state_e;

endpackage

// ===== src/ple_ram.sv =====
// ---------------------------------------------------------------------------
// ple_ram
// Generic memory with one write port and one read port, registered read.
// ---------------------------------------------------------------------------
module ple_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/positional_list_engine_unit.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values with insert and remove by position.
// ---------------------------------------------------------------------------
// Usage: a command word (command, value, position) is taken on the input
// valid/ready channel; exactly one result word (status, removed value,
// found, item count, empty flag) leaves on the output valid/ready channel.
// The block works on one command at a time and raises in_ready_o only when
// it is idle and its result register is empty.
// How each command runs, with n entries held:
//   clear, check position, full or empty cases: answered from idle, with no memory pass.
//   append, insert at position p: entries from p on move up, then the value is stored.
//   remove at position p (last = n): capture the entry, then move later entries down.
//   find key: scan from the first entry (stops at the first match).
// All entries live in one memory with a registered read port; the shift and
// the scan move one entry per cycle through that port.
// Reset empties the list at once; no clearing pass is needed. A result word
// waiting on a stalled receiver stays valid and unchanged, and no new
// command is taken until it leaves.
// ---------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] value_i,
  input  logic [6:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] removed_value_o,
  output logic        found_o,
  output logic [6:0]  item_count_o,
  output logic        is_empty_o
);
  import ple_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  ple_state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [31:0]   key_q, key_d;
  logic          wpend_q, wpend_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic          cap_q, cap_d;
  logic          cmp_q, cmp_d;
  logic          out_valid_q, out_valid_d;
  ple_status_e   status_q, status_d;
  logic [31:0]   removed_q, removed_d;
  logic          found_q, found_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [XW-1:0] pos_x, cnt_x;
  logic [CW-1:0] cnt_dec, k_dec;
  logic          accept, full;

  assign accept  = in_valid_i && in_ready_o;
  assign pos_x   = XW'(position_i);
  assign cnt_x   = XW'(count_q);
  assign full    = (cnt_x >= XW'(DEPTH));
  assign cnt_dec = count_q - CW'(1);
  assign k_dec   = k_q - CW'(1);

  // Entry storage.
  ple_ram #(
    .Width (32),
    .Depth (DEPTH)
  ) u_ple_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PLE_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      wpend_q     <= 1'b0;
      cap_q       <= 1'b0;
      cmp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      wpend_q     <= wpend_d;
      cap_q       <= cap_d;
      cmp_q       <= cmp_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    idx_q     <= idx_d;
    key_q     <= key_d;
    waddr_q   <= waddr_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  // Sequencer: next state, memory port control and result word.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    idx_d       = idx_q;
    key_d       = key_q;
    wpend_d     = wpend_q;
    waddr_d     = waddr_q;
    cap_d       = cap_q;
    cmp_d       = cmp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    removed_d   = removed_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_waddr   = waddr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = k_q[AW-1:0];

    case (state_q)
      PLE_IDLE: begin
        if (accept) begin
          key_d     = value_i;
          status_d  = ST_OK;
          removed_d = '0;
          found_d   = 1'b0;
          wpend_d   = 1'b0;
          cap_d     = 1'b0;
          cmp_d     = 1'b0;
          case (ple_cmd_e'(command_i))
            CMD_APPEND, CMD_INSERT_AT: begin
              if (full) begin
                status_d    = ST_FULL;
                out_valid_d = 1'b1;
              end else begin
                // Position zero or past the end appends.
                if (ple_cmd_e'(command_i) == CMD_APPEND || pos_x == '0 ||
                    pos_x > cnt_x + XW'(1)) begin
                  idx_d = count_q;
                end else begin
                  idx_d = CW'(pos_x - XW'(1));
                end
                k_d     = count_q;
                state_d = PLE_SHIFT_UP;
              end
            end
            CMD_REM_LAST, CMD_REM_AT: begin
              if (count_q == '0) begin
                status_d    = ST_EMPTY;
                out_valid_d = 1'b1;
              end else if (ple_cmd_e'(command_i) == CMD_REM_AT && pos_x != '0 &&
                           pos_x > cnt_x) begin
                status_d    = ST_BADPOS;
                out_valid_d = 1'b1;
              end else begin
                // Read the entry that leaves; the shift starts one above it.
                if (ple_cmd_e'(command_i) == CMD_REM_LAST || pos_x == '0) begin
                  idx_d = cnt_dec;
                end else begin
                  idx_d = CW'(pos_x - XW'(1));
                end
                ram_raddr = idx_d[AW-1:0];
                k_d       = idx_d + CW'(1);
                cap_d     = 1'b1;
                state_d   = PLE_SHIFT_DN;
              end
            end
            CMD_FIND_KEY: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
              end else begin
                k_d     = '0;
                state_d = PLE_SCAN;
              end
            end
            CMD_CHECK_POS: begin
              found_d     = (pos_x != '0) && (pos_x <= cnt_x);
              out_valid_d = 1'b1;
            end
            CMD_CLEAR: begin
              count_d     = '0;
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      // Move entries up one place, from the top down to the insert point.
      PLE_SHIFT_UP: begin
        ram_we = wpend_q;
        if (k_q > idx_q) begin
          ram_raddr = k_dec[AW-1:0];
          wpend_d   = 1'b1;
          waddr_d   = k_q[AW-1:0];
          k_d       = k_dec;
        end else begin
          wpend_d = 1'b0;
          state_d = PLE_PUT;
        end
      end

      // Store the new value in the opened place.
      PLE_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = idx_q[AW-1:0];
        ram_wdata   = key_q;
        count_d     = count_q + CW'(1);
        out_valid_d = 1'b1;
        state_d     = PLE_IDLE;
      end

      // Capture the removed entry, then move later entries down one place.
      PLE_SHIFT_DN: begin
        ram_we = wpend_q;
        cap_d  = 1'b0;
        if (cap_q) begin
          removed_d = ram_rdata;
        end
        if (k_q < count_q) begin
          ram_raddr = k_q[AW-1:0];
          wpend_d   = 1'b1;
          waddr_d   = k_dec[AW-1:0];
          k_d       = k_q + CW'(1);
        end else begin
          wpend_d     = 1'b0;
          count_d     = cnt_dec;
          out_valid_d = 1'b1;
          state_d     = PLE_IDLE;
        end
      end

      // Compare one entry per cycle against the key.
      PLE_SCAN: begin
        if (cmp_q && ram_rdata == key_q) begin
          found_d     = 1'b1;
          cmp_d       = 1'b0;
          out_valid_d = 1'b1;
          state_d     = PLE_IDLE;
        end else if (k_q < count_q) begin
          ram_raddr = k_q[AW-1:0];
          cmp_d     = 1'b1;
          k_d       = k_q + CW'(1);
        end else begin
          cmp_d       = 1'b0;
          out_valid_d = 1'b1;
          state_d     = PLE_IDLE;
        end
      end

      default: begin
        state_d = PLE_IDLE;
      end
    endcase
  end

  // Ports.
  assign in_ready_o      = (state_q == PLE_IDLE) && !out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign found_o         = found_q;
  assign item_count_o    = 7'(count_q);
  assign is_empty_o      = (count_q == '0);

endmodule

// ===== src/ple_checker.sv =====
// ---------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to its top level.
// ---------------------------------------------------------------------------
`include "positional_list_engine_unit_defines.svh"

module ple_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  command_i,
  input logic [31:0] value_i,
  input logic [6:0]  position_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] removed_value_o,
  input logic        found_o,
  input logic [6:0]  item_count_o,
  input logic        is_empty_o
);

  // A stalled result word stays valid.
  `PLE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")

  // No new command is taken while a result word is waiting.
  `PLE_ASSERT_IMPL(a_one_at_a_time, out_valid_o, !in_ready_o, "ready while result pending")

  // Once a command is taken the block is busy in the next cycle.
  `PLE_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o,
              "ready right after accept")

  // The empty flag agrees with the count.
  `PLE_ASSERT(a_empty_flag, is_empty_o == (item_count_o == 7'd0), "empty flag mismatch")

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);

// ===== dv/ple_list_checker.sv =====
// ---------------------------------------------------------------------------
// ple_list_checker
// Watches both channels of the positional list engine, predicts each result
// word from its own copy of the list, and compares every field.
// ---------------------------------------------------------------------------
module ple_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] value_i,
  input  logic [6:0]  position_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] removed_value_i,
  input  logic        found_i,
  input  logic [6:0]  item_count_i,
  input  logic        is_empty_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int ListDepth = 64;

  // One predicted result word.
  typedef struct packed {
    ple_status_e status;
    logic [31:0] removed;
    logic        found;
    logic [6:0]  count;
    logic        empty;
  } list_result_t;

  logic [31:0]  list_mem [ListDepth];
  int           list_len;
  list_result_t result_q [$];
  list_result_t want_r;
  int           fail_total;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fail_total++;
  endtask

  // Runs one command on the shadow list and returns the result it gives.
  function automatic list_result_t apply_command(input logic [2:0] cmd,
                                                 input logic [31:0] val,
                                                 input logic [6:0] pos);
    list_result_t res;
    int idx;
    int k;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_APPEND, CMD_INSERT_AT: begin
        if (list_len >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          // Position zero or past the end falls back to an append.
          idx = list_len;
          if (cmd == CMD_INSERT_AT && pos != 0 && int'(pos) <= list_len + 1) begin
            idx = int'(pos) - 1;
          end
          for (k = list_len; k > idx; k--) begin
            list_mem[k] = list_mem[k-1];
          end
          list_mem[idx] = val;
          list_len++;
        end
      end
      CMD_REM_LAST, CMD_REM_AT: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_REM_AT && int'(pos) > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          // Position zero takes the last entry, like remove last.
          idx = (cmd == CMD_REM_AT && pos != 0) ? int'(pos) - 1 : list_len - 1;
          res.removed = list_mem[idx];
          for (k = idx; k + 1 < list_len; k++) begin
            list_mem[k] = list_mem[k+1];
          end
          list_len--;
        end
      end
      CMD_FIND_KEY: begin
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == val) begin
            res.found = 1'b1;
          end
        end
      end
      CMD_CHECK_POS: begin
        res.found = (pos >= 1 && int'(pos) <= list_len);
      end
      CMD_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.count = list_len[6:0];
    res.empty = (list_len == 0);
    return res;
  endfunction

  // Compare the outgoing word first, then predict the incoming one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      result_q.delete();
      fail_total = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result word with none expected (status %0d, count %0d)",
                                    status_i, item_count_i));
        end else begin
          want_r = result_q.pop_front();
          if (status_i !== want_r.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want_r.status));
          end
          if (removed_value_i !== want_r.removed) begin
            report_mismatch($sformatf("removed_value %h, expected %h",
                                      removed_value_i, want_r.removed));
          end
          if (found_i !== want_r.found) begin
            report_mismatch($sformatf("found %b, expected %b", found_i, want_r.found));
          end
          if (item_count_i !== want_r.count) begin
            report_mismatch($sformatf("item_count %0d, expected %0d",
                                      item_count_i, want_r.count));
          end
          if (is_empty_i !== want_r.empty) begin
            report_mismatch($sformatf("is_empty %b, expected %b", is_empty_i, want_r.empty));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(apply_command(command_i, value_i, position_i));
      end
      fail_count_o <= fail_total;
      pending_o <= result_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Top level for the positional list engine: drives command words, stalls
// both channels at random and gives the verdict from the checker's count.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int RandomWords = 700;
  localparam int CycleLimit = 500000;
  localparam int ModeGrow = 0;
  localparam int ModeShrink = 1;
  localparam int ModeMix = 2;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  command_i;
  logic [31:0] value_i;
  logic [6:0]  position_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] removed_value_o;
  logic        found_o;
  logic [6:0]  item_count_o;
  logic        is_empty_o;
  int          fail_count;
  int          pending;

  int          cycle_cnt;
  bit          no_stall;
  int          est_len;
  logic [31:0] word_pool [8];

  positional_list_engine_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .found_o        (found_o),
    .item_count_o   (item_count_o),
    .is_empty_o     (is_empty_o)
  );

  ple_list_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .removed_value_i(removed_value_o),
    .found_i        (found_o),
    .item_count_i   (item_count_o),
    .is_empty_i     (is_empty_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver stalls at random, with a chance of about 14 in a hundred, except in the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(0, 99) >= 14);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("[positional_list_engine_unit] ERROR");
      $finish;
    end
  end

  // Offers one command word, with a random idle gap in front of it.
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] val,
                           input logic [6:0] pos);
    int gap;
    gap = 0;
    if (!no_stall) begin
      while ($urandom_range(0, 99) < 14) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    // Rough count of entries, used only to aim positions near the end.
    case (cmd)
      CMD_APPEND, CMD_INSERT_AT: if (est_len < 64) est_len++;
      CMD_REM_LAST: if (est_len > 0) est_len--;
      CMD_REM_AT: if (est_len > 0 && int'(pos) <= est_len) est_len--;
      CMD_CLEAR: est_len = 0;
      default: begin
      end
    endcase
  endtask

  // Holds the input channel low until every result word has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One random command word shaped by the burst mode.
  task automatic random_word(input int mode);
    int roll;
    int pick;
    int hi;
    logic [2:0]  cmd;
    logic [31:0] val;
    logic [6:0]  pos;
    roll = $urandom_range(0, 99);
    case (mode)
      ModeGrow:
        cmd = roll < 45 ? CMD_APPEND : roll < 80 ? CMD_INSERT_AT :
              roll < 88 ? CMD_FIND_KEY : roll < 94 ? CMD_CHECK_POS :
              roll < 98 ? CMD_REM_AT : CMD_REM_LAST;
      ModeShrink:
        cmd = roll < 40 ? CMD_REM_AT : roll < 70 ? CMD_REM_LAST :
              roll < 80 ? CMD_FIND_KEY : roll < 90 ? CMD_CHECK_POS :
              roll < 98 ? CMD_APPEND : CMD_INSERT_AT;
      default:
        cmd = roll < 15 ? CMD_APPEND : roll < 35 ? CMD_INSERT_AT :
              roll < 47 ? CMD_REM_LAST : roll < 67 ? CMD_REM_AT :
              roll < 82 ? CMD_FIND_KEY : roll < 94 ? CMD_CHECK_POS :
              roll < 97 ? CMD_CLEAR : CmdUnused;
    endcase
    // Pool values make searches hit entries that are really held.
    val = $urandom_range(0, 1) ? word_pool[$urandom_range(0, 7)] : $urandom;
    hi = (est_len + 1 > 64) ? 64 : est_len + 1;
    pick = $urandom_range(0, 9);
    case (pick)
      0: pos = 7'd0;
      1: pos = 7'(est_len);
      2: pos = 7'(hi);
      3, 4: pos = 7'($urandom_range(0, 64));
      default: pos = 7'($urandom_range(1, hi));
    endcase
    send_word(cmd, val, pos);
  endtask

  // Stimulus and verdict.
  initial begin
    int sent;
    int burst;
    int mode;
    int burst_len;
    int i;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    command_i   = CMD_APPEND;
    value_i     = '0;
    position_i  = '0;
    cycle_cnt   = 0;
    no_stall    = 1'b0;
    est_len     = 0;
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7fff_ffff;
    word_pool[2] = 32'hffff_ffff;
    word_pool[3] = 32'h0000_0000;
    for (i = 4; i < 8; i++) word_pool[i] = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list cases, extremes, positions at and past the end.
    send_word(CMD_REM_LAST,  32'd0,         7'd0);
    send_word(CMD_REM_AT,    32'd0,         7'd3);
    send_word(CMD_FIND_KEY,  32'd0,         7'd0);
    send_word(CMD_CHECK_POS, 32'd0,         7'd1);
    send_word(CMD_APPEND,    32'h8000_0000, 7'd0);
    send_word(CMD_APPEND,    32'h7fff_ffff, 7'd64);
    send_word(CMD_INSERT_AT, 32'hffff_ffff, 7'd1);
    send_word(CMD_INSERT_AT, 32'h0000_0000, 7'd0);
    send_word(CMD_INSERT_AT, 32'h0000_0001, 7'd64);
    send_word(CMD_INSERT_AT, 32'h0000_0002, 7'd6);
    send_word(CMD_INSERT_AT, 32'h5555_5555, 7'd3);
    send_word(CMD_FIND_KEY,  32'h7fff_ffff, 7'd0);
    send_word(CMD_FIND_KEY,  32'h1234_5678, 7'd0);
    send_word(CMD_CHECK_POS, 32'd0,         7'd0);
    send_word(CMD_CHECK_POS, 32'd0,         7'd7);
    send_word(CMD_CHECK_POS, 32'd0,         7'd8);
    send_word(CMD_CHECK_POS, 32'd0,         7'd64);
    send_word(CMD_REM_AT,    32'd0,         7'd0);
    send_word(CMD_REM_AT,    32'd0,         7'd64);
    send_word(CMD_REM_AT,    32'd0,         7'd1);
    send_word(CMD_REM_AT,    32'd0,         7'd3);
    send_word(CMD_REM_LAST,  32'd0,         7'd0);
    send_word(CmdUnused,     32'hffff_ffff, 7'd127);
    send_word(CMD_CLEAR,     32'd0,         7'd0);
    send_word(CMD_REM_AT,    32'd0,         7'd0);
    wait_drained();

    // Random bursts: a growing burst first, then a shrinking one, then a mix.
    sent = 0;
    burst = 0;
    while (sent < RandomWords) begin
      mode = (burst == 0) ? ModeGrow : (burst == 1) ? ModeShrink : $urandom_range(0, 2);
      burst_len = (burst < 2) ? 90 : $urandom_range(20, 80);
      for (i = 0; i < burst_len && sent < RandomWords; i++) begin
        no_stall = (sent >= 250 && sent < 400);
        random_word(mode);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
      burst++;
    end

    // Let the last results out and watch for stray words.
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[positional_list_engine_unit] OK");
    end else begin
      $display("[positional_list_engine_unit] ERROR");
    end
    $finish;
  end

endmodule
